// ===== hdl/spn_pkg.sv =====
package spn_pkg;

  localparam int unsigned LAYER_ROUNDS = 28;
  localparam int unsigned CORE_ROUNDS  = 24;
  localparam int unsigned STAGES       = 2 * LAYER_ROUNDS + CORE_ROUNDS;
  localparam int unsigned RC_COUNT     = 28;
  localparam int unsigned KEY_COUNT    = 4;
  localparam int unsigned BLOCK_W      = 128;
  localparam int unsigned HALF_W       = 64;
  localparam int unsigned RED_W        = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned SCHED_CNT_W  = 4;

  // index of the last keyless round before each chained round key
  localparam logic [1:0] KEYLESS_LAST = 2'd3;
  // last step of the chained schedule (three keys, four rounds each)
  localparam logic [SCHED_CNT_W-1:0] SCHED_LAST = 4'd11;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_ROUNDS = 3'd4;

  localparam logic [RED_W-1:0] RED_ROUNDS_RESET = 5'd28;

  localparam logic [3:0] LAYER_BOX [16] = '{
    4'h0, 4'h3, 4'h7, 4'he, 4'hd, 4'h4, 4'ha, 4'h9,
    4'hc, 4'hf, 4'h1, 4'h8, 4'hb, 4'h2, 4'h6, 4'h5
  };

  localparam logic [3:0] CORE_BOX [16] = '{
    4'h1, 4'h9, 4'h6, 4'hf, 4'h7, 4'hc, 4'h8, 4'h2,
    4'ha, 4'he, 4'hd, 4'h0, 4'h4, 4'h3, 4'hb, 4'h5
  };

  localparam logic [5:0] RC [RC_COUNT] = '{
    6'd1,  6'd3,  6'd7,  6'd15, 6'd31, 6'd62, 6'd61, 6'd59, 6'd55, 6'd47,
    6'd30, 6'd60, 6'd57, 6'd51, 6'd39, 6'd14, 6'd29, 6'd58, 6'd53, 6'd43,
    6'd22, 6'd44, 6'd24, 6'd48, 6'd33, 6'd2,  6'd5,  6'd11
  };

  localparam logic [6:0] PERM [BLOCK_W] = '{
    7'd0,   7'd33,  7'd66,  7'd99,  7'd96,  7'd1,   7'd34,  7'd67,
    7'd64,  7'd97,  7'd2,   7'd35,  7'd32,  7'd65,  7'd98,  7'd3,
    7'd4,   7'd37,  7'd70,  7'd103, 7'd100, 7'd5,   7'd38,  7'd71,
    7'd68,  7'd101, 7'd6,   7'd39,  7'd36,  7'd69,  7'd102, 7'd7,
    7'd8,   7'd41,  7'd74,  7'd107, 7'd104, 7'd9,   7'd42,  7'd75,
    7'd72,  7'd105, 7'd10,  7'd43,  7'd40,  7'd73,  7'd106, 7'd11,
    7'd12,  7'd45,  7'd78,  7'd111, 7'd108, 7'd13,  7'd46,  7'd79,
    7'd76,  7'd109, 7'd14,  7'd47,  7'd44,  7'd77,  7'd110, 7'd15,
    7'd16,  7'd49,  7'd82,  7'd115, 7'd112, 7'd17,  7'd50,  7'd83,
    7'd80,  7'd113, 7'd18,  7'd51,  7'd48,  7'd81,  7'd114, 7'd19,
    7'd20,  7'd53,  7'd86,  7'd119, 7'd116, 7'd21,  7'd54,  7'd87,
    7'd84,  7'd117, 7'd22,  7'd55,  7'd52,  7'd85,  7'd118, 7'd23,
    7'd24,  7'd57,  7'd90,  7'd123, 7'd120, 7'd25,  7'd58,  7'd91,
    7'd88,  7'd121, 7'd26,  7'd59,  7'd56,  7'd89,  7'd122, 7'd27,
    7'd28,  7'd61,  7'd94,  7'd127, 7'd124, 7'd29,  7'd62,  7'd95,
    7'd92,  7'd125, 7'd30,  7'd63,  7'd60,  7'd93,  7'd126, 7'd31
  };

  typedef struct packed {
    logic [HALF_W-1:0] plaintext_high;
    logic [HALF_W-1:0] plaintext_low;
  } in_t;

  typedef struct packed {
    logic [HALF_W-1:0] ciphertext_high;
    logic [HALF_W-1:0] ciphertext_low;
  } out_t;

  // per-stage round control
  typedef struct packed {
    logic       active;
    logic       core;
    logic [5:0] rc;
  } stage_ctl_t;

  // key schedule load request
  typedef struct packed {
    logic               start;
    logic               chain;
    logic [BLOCK_W-1:0] master;
  } ks_cfg_t;

  function automatic logic [BLOCK_W-1:0] substitute(input logic [BLOCK_W-1:0] st,
                                                    input logic core);
    logic [BLOCK_W-1:0] res;
    res = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      res[4*n +: 4] = core ? CORE_BOX[st[4*n +: 4]] : LAYER_BOX[st[4*n +: 4]];
    end
    return res;
  endfunction

  function automatic logic [BLOCK_W-1:0] permute(input logic [BLOCK_W-1:0] st);
    logic [BLOCK_W-1:0] res;
    res = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      res[PERM[i]] = st[i];
    end
    return res;
  endfunction

  function automatic logic [BLOCK_W-1:0] keyless_round(input logic [BLOCK_W-1:0] st);
    logic [BLOCK_W-1:0] res;
    res = permute(substitute(st, 1'b0));
    res[BLOCK_W-1] = ~res[BLOCK_W-1];
    return res;
  endfunction

  function automatic logic [BLOCK_W-1:0] full_round(input logic [BLOCK_W-1:0] st,
                                                    input logic core,
                                                    input logic [5:0] rc,
                                                    input logic [BLOCK_W-1:0] key);
    logic [BLOCK_W-1:0] res;
    res = permute(substitute(st, core));
    res[BLOCK_W-1] = ~res[BLOCK_W-1];
    res[23] = res[23] ^ rc[5];
    res[19] = res[19] ^ rc[4];
    res[15] = res[15] ^ rc[3];
    res[11] = res[11] ^ rc[2];
    res[7]  = res[7]  ^ rc[1];
    res[3]  = res[3]  ^ rc[0];
    return res ^ key;
  endfunction

endpackage

// ===== hdl/spn_block_cipher_128_encrypt_core.sv =====
// 128-bit block cipher encryption core, one round per pipeline stage. Every transaction
// passes all stages (two runs of 28 layer rounds around 24 core rounds), in full and
// reduced mode alike: in reduced mode the unused stages simply carry the block along.
// A new block is taken every cycle while the key sequencer is idle; the whole pipeline
// holds while a finished result waits at the output. Any write to a known register
// reloads the round keys; with the chained key schedule the key sequencer then steps
// one keyless round per cycle through its 12 schedule steps, and in_ready_o stays low
// meanwhile. Write the configuration only while no transaction is in flight.
module spn_block_cipher_128_encrypt_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // plaintext channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  spn_pkg::in_t                  in_data_i,
  // ciphertext channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output spn_pkg::out_t                 out_data_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [spn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spn_pkg::HALF_W-1:0]    cfg_wdata_i
);

  localparam int unsigned L = spn_pkg::LAYER_ROUNDS;
  localparam int unsigned C = spn_pkg::CORE_ROUNDS;

  // configuration registers
  logic [spn_pkg::HALF_W-1:0] key_high_q, key_high_d;
  logic [spn_pkg::HALF_W-1:0] key_low_q, key_low_d;
  logic                       sched_mode_q, sched_mode_d;
  logic                       cipher_mode_q, cipher_mode_d;
  logic [spn_pkg::RED_W-1:0]  red_rounds_q, red_rounds_d;
  logic                       cfg_hit;

  always_comb begin
    key_high_d    = key_high_q;
    key_low_d     = key_low_q;
    sched_mode_d  = sched_mode_q;
    cipher_mode_d = cipher_mode_q;
    red_rounds_d  = red_rounds_q;
    cfg_hit       = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spn_pkg::CFG_KEY_HIGH: begin
          key_high_d = cfg_wdata_i;
          cfg_hit    = 1'b1;
        end
        spn_pkg::CFG_KEY_LOW: begin
          key_low_d = cfg_wdata_i;
          cfg_hit   = 1'b1;
        end
        spn_pkg::CFG_SCHED_MODE: begin
          sched_mode_d = cfg_wdata_i[0];
          cfg_hit      = 1'b1;
        end
        spn_pkg::CFG_CIPHER_MODE: begin
          cipher_mode_d = cfg_wdata_i[0];
          cfg_hit       = 1'b1;
        end
        spn_pkg::CFG_RED_ROUNDS: begin
          red_rounds_d = cfg_wdata_i[spn_pkg::RED_W-1:0];
          cfg_hit      = 1'b1;
        end
        // unknown indexes are ignored
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q    <= '0;
      key_low_q     <= '0;
      sched_mode_q  <= 1'b0;
      cipher_mode_q <= 1'b0;
      red_rounds_q  <= spn_pkg::RED_ROUNDS_RESET;
    end else begin
      key_high_q    <= key_high_d;
      key_low_q     <= key_low_d;
      sched_mode_q  <= sched_mode_d;
      cipher_mode_q <= cipher_mode_d;
      red_rounds_q  <= red_rounds_d;
    end
  end

  // key schedule, loaded with the values being written
  spn_pkg::ks_cfg_t ks_cfg;
  logic [spn_pkg::KEY_COUNT-1:0][spn_pkg::BLOCK_W-1:0] rk;
  logic ks_busy;

  assign ks_cfg.start  = cfg_hit;
  assign ks_cfg.chain  = sched_mode_d;
  assign ks_cfg.master = {key_high_d, key_low_d};

  spn_key_sched u_key_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (ks_cfg),
    .rk_o   (rk),
    .busy_o (ks_busy)
  );

  // whole pipeline advances together unless the output holds a waiting result
  logic adv;
  logic                        valid_s [spn_pkg::STAGES+1];
  logic [spn_pkg::BLOCK_W-1:0] data_s  [spn_pkg::STAGES+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv && !ks_busy;
  assign valid_s[0] = in_valid_i && !ks_busy;
  assign data_s[0]  = {in_data_i.plaintext_high, in_data_i.plaintext_low};

  for (genvar s = 0; s < spn_pkg::STAGES; s++) begin : g_stage
    // first layer run, core run, second layer run; each counts rounds from 0
    localparam bit          FIRST   = (s < L);
    localparam bit          IS_CORE = (s >= L) && (s < L + C);
    localparam int unsigned R       = (s < L) ? s : ((s < L + C) ? s - L : s - L - C);

    spn_pkg::stage_ctl_t ctl;

    // reduced mode keeps only the first reduced_rounds layer rounds; a count past
    // the layer run saturates on its own since the first run ends there
    assign ctl.active = !cipher_mode_q ||
                        (FIRST && (spn_pkg::RED_W'(R) < red_rounds_q));
    assign ctl.core   = IS_CORE;
    assign ctl.rc     = spn_pkg::RC[R % spn_pkg::RC_COUNT];

    spn_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[s]),
      .data_i  (data_s[s]),
      .ctl_i   (ctl),
      .key_i   (rk[R % spn_pkg::KEY_COUNT]),
      .valid_o (valid_s[s+1]),
      .data_o  (data_s[s+1])
    );
  end

  // last stage register is the output register
  assign out_valid_o                = valid_s[spn_pkg::STAGES];
  assign out_data_o.ciphertext_high = data_s[spn_pkg::STAGES][spn_pkg::BLOCK_W-1:spn_pkg::HALF_W];
  assign out_data_o.ciphertext_low  = data_s[spn_pkg::STAGES][spn_pkg::HALF_W-1:0];

endmodule

// ===== hdl/spn_key_sched.sv =====
module spn_key_sched (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  spn_pkg::ks_cfg_t                             cfg_i,
  output logic [spn_pkg::KEY_COUNT-1:0][spn_pkg::BLOCK_W-1:0] rk_o,
  output logic                                         busy_o
);

  logic [spn_pkg::KEY_COUNT-1:0][spn_pkg::BLOCK_W-1:0] rk_q;
  logic [spn_pkg::BLOCK_W-1:0]     st_q, st_d;
  logic [spn_pkg::SCHED_CNT_W-1:0] cnt_q;
  logic                            busy_q;

  assign st_d = spn_pkg::keyless_round(st_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (cfg_i.start) begin
      for (int k = 0; k < spn_pkg::KEY_COUNT; k++) begin
        rk_q[k] <= cfg_i.master;
      end
      cnt_q  <= '0;
      busy_q <= cfg_i.chain;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      // every fourth keyless round yields the next key
      if (cnt_q[1:0] == spn_pkg::KEYLESS_LAST) begin
        rk_q[cnt_q[3:2] + 2'd1] <= st_d;
      end
      if (cnt_q == spn_pkg::SCHED_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // chaining state, no reset needed
  always_ff @(posedge clk_i) begin
    if (cfg_i.start) begin
      st_q <= cfg_i.master;
    end else if (busy_q) begin
      st_q <= st_d;
    end
  end

  assign rk_o   = rk_q;
  assign busy_o = busy_q;

endmodule

// ===== hdl/spn_stage.sv =====
module spn_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [spn_pkg::BLOCK_W-1:0] data_i,
  input  spn_pkg::stage_ctl_t         ctl_i,
  input  logic [spn_pkg::BLOCK_W-1:0] key_i,
  output logic                        valid_o,
  output logic [spn_pkg::BLOCK_W-1:0] data_o
);

  logic                        valid_q;
  logic [spn_pkg::BLOCK_W-1:0] data_q, data_d;

  // skipped rounds pass the state through untouched
  assign data_d = ctl_i.active ? spn_pkg::full_round(data_i, ctl_i.core, ctl_i.rc, key_i)
                               : data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
